### sv/psd_pkg.sv
// Shared constants and types for the point to segment distance unit.
`default_nettype none
package psd_pkg;
	localparam int COORD_W = 16;              // field width of every coordinate
	localparam int DW      = COORD_W + 1;     // difference of two coordinates
	localparam int LW      = 2 * DW;          // squared length, cross magnitude
	localparam int XW      = LW + 1;          // signed dot and cross products
	localparam int HW      = LW / 2;          // half of a cross magnitude
	localparam int RW      = 2 * LW + 2;      // remainder and trial terms
	localparam int DIST_W  = 17;
	localparam int NB      = DIST_W + 1;      // result bits, one per cell
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_END1_X = 2'd0;
	localparam logic [IDX_W-1:0] REG_END1_Y = 2'd1;
	localparam logic [IDX_W-1:0] REG_END2_X = 2'd2;
	localparam logic [IDX_W-1:0] REG_END2_Y = 2'd3;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	typedef struct packed {
		logic          valid;
		logic          onseg;
		logic [RW-1:0] r;
		logic [RW-1:0] a;
		logic [RW-1:0] b;
		logic [NB-1:0] d;
	} cell_t;
endpackage
`default_nettype wire

### sv/psd_if.sv
// Request channels: query points in, distance results out.
`default_nettype none
interface psd_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [psd_pkg::COORD_W-1:0] point_x;
	logic signed [psd_pkg::COORD_W-1:0] point_y;
	modport source(output valid, point_x, point_y, input ready);
	modport sink(input valid, point_x, point_y, output ready);
endinterface

interface psd_out_if;
	logic                              valid;
	logic                              ready;
	logic                              on_segment;
	logic [psd_pkg::DIST_W-1:0]        distance;
	modport source(output valid, on_segment, distance, input ready);
	modport sink(input valid, on_segment, distance, output ready);
endinterface
`default_nettype wire

### sv/psd_front.sv
// Front stages: differences, products, range test and squared cross term.
`default_nettype none
module psd_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        load,
	input  wire logic [psd_pkg::COORD_W-1:0] point_x,
	input  wire logic [psd_pkg::COORD_W-1:0] point_y,
	input  wire logic [psd_pkg::COORD_W-1:0] end1_x,
	input  wire logic [psd_pkg::COORD_W-1:0] end1_y,
	input  wire logic [psd_pkg::COORD_W-1:0] end2_x,
	input  wire logic [psd_pkg::COORD_W-1:0] end2_y,
	output psd_pkg::cell_t                   cell_out
);
	logic signed [psd_pkg::DW-1:0] dx, dy, vx, vy;
	logic signed [psd_pkg::DW-1:0] vx_s1, vy_s1;
	logic                          v_s1, v_s2, v_s3, v_s4;
	logic signed [psd_pkg::LW-1:0] p_vxdx, p_vydy, p_dxvy, p_dyvx, p_dxdx, p_dydy, p_vxvx, p_vyvy;
	logic signed [psd_pkg::XW-1:0] dot_s2, cross_s2;
	logic [psd_pkg::LW-1:0]        len_s2, vv_s2, len_s3, vv_s3, cmag;
	logic                          on_s3, zero_s3;
	logic [psd_pkg::LW-1:0]        ll_s3, hl_s3, hh_s3;
	logic [psd_pkg::RW-1:0]        c2;
	logic                          onseg_s4;
	logic [psd_pkg::RW-1:0]        r_s4, b_s4;

	assign dx = psd_pkg::DW'($signed(end2_x)) - psd_pkg::DW'($signed(end1_x));
	assign dy = psd_pkg::DW'($signed(end2_y)) - psd_pkg::DW'($signed(end1_y));
	assign vx = psd_pkg::DW'($signed(point_x)) - psd_pkg::DW'($signed(end1_x));
	assign vy = psd_pkg::DW'($signed(point_y)) - psd_pkg::DW'($signed(end1_y));

	assign p_vxdx = vx_s1 * dx;
	assign p_vydy = vy_s1 * dy;
	assign p_dxvy = dx * vy_s1;
	assign p_dyvx = dy * vx_s1;
	assign p_dxdx = dx * dx;
	assign p_dydy = dy * dy;
	assign p_vxvx = vx_s1 * vx_s1;
	assign p_vyvy = vy_s1 * vy_s1;

	assign cmag = cross_s2[psd_pkg::XW-1] ? psd_pkg::LW'(-cross_s2) : psd_pkg::LW'(cross_s2);
	assign c2 = (psd_pkg::RW'(hh_s3) << (2 * psd_pkg::HW))
		+ (psd_pkg::RW'(hl_s3) << (psd_pkg::HW + 1)) + psd_pkg::RW'(ll_s3);

	assign cell_out = {v_s4, onseg_s4, r_s4, {psd_pkg::RW{1'b0}}, b_s4, {psd_pkg::NB{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= load;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1    <= vx;
			vy_s1    <= vy;
			dot_s2   <= psd_pkg::XW'(p_vxdx) + psd_pkg::XW'(p_vydy);
			cross_s2 <= psd_pkg::XW'(p_dxvy) - psd_pkg::XW'(p_dyvx);
			len_s2   <= psd_pkg::LW'(p_dxdx + p_dydy);
			vv_s2    <= psd_pkg::LW'(p_vxvx + p_vyvy);
			on_s3    <= !dot_s2[psd_pkg::XW-1] && (dot_s2 <= $signed({1'b0, len_s2}));
			zero_s3  <= (len_s2 == '0);
			len_s3   <= len_s2;
			vv_s3    <= vv_s2;
			ll_s3    <= cmag[psd_pkg::HW-1:0] * cmag[psd_pkg::HW-1:0];
			hl_s3    <= cmag[psd_pkg::LW-1:psd_pkg::HW] * cmag[psd_pkg::HW-1:0];
			hh_s3    <= cmag[psd_pkg::LW-1:psd_pkg::HW] * cmag[psd_pkg::LW-1:psd_pkg::HW];
			// degenerate segment: distance to the first endpoint, divisor one
			onseg_s4 <= on_s3 || zero_s3;
			r_s4     <= zero_s3 ? psd_pkg::RW'(vv_s3) : c2;
			b_s4     <= (zero_s3 ? psd_pkg::RW'(1) : psd_pkg::RW'(len_s3))
				<< (2 * (psd_pkg::NB - 1));
		end
	end
endmodule
`default_nettype wire

### sv/psd_cell.sv
// One result bit of floor(sqrt(r / len)): trial subtract, then hand on.
`default_nettype none
module psd_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  psd_pkg::cell_t  cell_in,
	output psd_pkg::cell_t  cell_out
);
	logic [psd_pkg::RW:0]   trial;
	logic                   take;
	logic                   valid_q, onseg_q;
	logic [psd_pkg::RW-1:0] r_q, a_q, b_q;
	logic [psd_pkg::NB-1:0] d_q;

	assign trial = {1'b0, cell_in.a} + {1'b0, cell_in.b};
	assign take  = trial <= {1'b0, cell_in.r};

	assign cell_out = {valid_q, onseg_q, r_q, a_q, b_q, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= cell_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			onseg_q <= cell_in.onseg;
			r_q     <= take ? cell_in.r - trial[psd_pkg::RW-1:0] : cell_in.r;
			a_q     <= take ? (cell_in.a >> 1) + cell_in.b : cell_in.a >> 1;
			b_q     <= cell_in.b >> 2;
			d_q     <= {cell_in.d[psd_pkg::NB-2:0], take};
		end
	end
endmodule
`default_nettype wire

### sv/point_segment_distance_unit.sv
// Top level: configuration registers, front stages, cell row, output register.
// Pipeline: 4 front stages, 18 cells and one output register lie between request
// accept and result valid. Throughput: one request per cycle; the whole
// pipeline holds while a result waits untaken. arst_n clears all valid bits
// and sets the four endpoint registers to zero.
`default_nettype none
module point_segment_distance_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [psd_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [psd_pkg::COORD_W-1:0] cfg_data,
	psd_in_if.sink                           pts,
	psd_out_if.source                        res
);
	logic [psd_pkg::COORD_W-1:0] end1_x_q, end1_y_q, end2_x_q, end2_y_q;
	logic                        en;
	logic                        out_valid_q, out_on_q;
	logic [psd_pkg::DIST_W-1:0]  out_dist_q;
	psd_pkg::cell_t              chain [psd_pkg::NB+1];
	psd_pkg::cell_t              last;

	assign en        = !out_valid_q || res.ready;
	assign pts.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end1_x_q <= '0;
			end1_y_q <= '0;
			end2_x_q <= '0;
			end2_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				psd_pkg::REG_END1_X: end1_x_q <= cfg_data;
				psd_pkg::REG_END1_Y: end1_y_q <= cfg_data;
				psd_pkg::REG_END2_X: end2_x_q <= cfg_data;
				psd_pkg::REG_END2_Y: end2_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	psd_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .load(pts.valid),
		.point_x(pts.point_x), .point_y(pts.point_y),
		.end1_x(end1_x_q), .end1_y(end1_y_q), .end2_x(end2_x_q), .end2_y(end2_y_q),
		.cell_out(chain[0])
	);

	for (genvar i = 0; i < psd_pkg::NB; i++) begin : g_cell
		psd_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.cell_in(chain[i]), .cell_out(chain[i+1])
		);
	end

	assign last = chain[psd_pkg::NB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_on_q <= last.onseg;
			// drop distance off segment, saturate past the field
			if (!last.onseg) begin
				out_dist_q <= '0;
			end else if (last.d[psd_pkg::NB-1]) begin
				out_dist_q <= psd_pkg::DIST_MAX;
			end else begin
				out_dist_q <= last.d[psd_pkg::DIST_W-1:0];
			end
		end
	end

	assign res.valid      = out_valid_q;
	assign res.on_segment = out_on_q;
	assign res.distance   = out_dist_q;

`ifndef NO_ASSERTIONS
	a_zero_off: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.on_segment |-> res.distance == '0)
		else $error("off-segment result with nonzero distance");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pts.ready |-> res.valid && !res.ready)
		else $error("input held without a waiting result");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pts.valid && pts.ready |=> u_front.v_s1)
		else $error("accepted request lost at first stage");
`endif
endmodule
`default_nettype wire
